// ----- hdl/swbr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register map and sequencer state type for the scroll window remap unit.
// No dependencies.
package swbr_pkg;

    // Line count of the display on the scroll axis
    localparam int MAX_LINES = 512;

    // Field widths: coordinates, sizes, and internal address arithmetic
    localparam int COORD_W  = $clog2(MAX_LINES);
    localparam int SIZE_W   = COORD_W + 1;
    localparam int ADDR_W   = COORD_W + 2;
    localparam int ITER_W   = $clog2(ADDR_W);

    // Configuration port geometry
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 3;

    // Register indexes
    localparam logic [REGIDX_W-1:0] REG_FIXED_START   = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_SCROLL_SPAN   = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_SCROLL_OFFSET = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_HW_SCROLL_ON  = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_ALONG_Y       = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_AXIS_INVERTED = 3'd5;

    // Maximum number of segments per rectangle, minus one
    localparam logic [1:0] LAST_SEG = 2'd3;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SEG  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

endpackage

// ----- hdl/scroll_window_blit_remap_unit.sv -----
`timescale 1ns / 1ps
// Each segment outside the scroll window passes through ST_SEG and ST_OUT; one inside it also
// passes through ST_DIV and ST_FIN, where an 11-step restoring remainder loop (one shared
// compare-subtract) reduces the line address. One rectangle is handled at a time (at most two
// segments fall inside the window, as it wraps only once); an empty rectangle is dropped at once.
// The next rectangle is taken once the last segment has been loaded into the output register.
// Reset (rst_n, asynchronous, active low) idles the sequencer, drops out_valid and returns the
// registers to: fixed_start 0, scroll_span 0, scroll_offset 0, scrolling off, Y axis, not inverted.
module scroll_window_blit_remap_unit
    import swbr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    // Rectangle requests
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [COORD_W-1:0]  x_start,
    input  logic [COORD_W-1:0]  y_start,
    input  logic [SIZE_W-1:0]   rect_width,
    input  logic [SIZE_W-1:0]   rect_height,

    // Segment requests
    output logic                out_valid,
    input  logic                out_stall,
    output logic [COORD_W-1:0]  dst_x,
    output logic [COORD_W-1:0]  dst_y,
    output logic [SIZE_W-1:0]   seg_width,
    output logic [SIZE_W-1:0]   seg_height,
    output logic [COORD_W-1:0]  src_start,
    output logic                last
);

    // Configuration registers
    logic [COORD_W-1:0] fixed_start_reg;
    logic [SIZE_W-1:0]  scroll_span_reg;
    logic [COORD_W-1:0] scroll_offset_reg;
    logic               hw_scroll_on_reg;
    logic               along_y_reg;
    logic               axis_inverted_reg;

    logic [REGIDX_W-1:0] reg_idx;
    logic                cfg_wr;

    // Sequencer and request registers
    state_t             state_reg, state_next;
    logic [COORD_W-1:0] x0_reg, x0_next;
    logic [COORD_W-1:0] y0_reg, y0_next;
    logic [SIZE_W-1:0]  w_reg, w_next;
    logic [SIZE_W-1:0]  h_reg, h_next;
    logic [COORD_W-1:0] start_reg, start_next;
    logic [SIZE_W-1:0]  len_reg, len_next;
    logic [SIZE_W-1:0]  pos_reg, pos_next;
    logic [1:0]         nseg_reg, nseg_next;
    logic               pass_reg, pass_next;
    logic               neg_reg, neg_next;
    logic [ADDR_W-1:0]  dvd_reg, dvd_next;
    logic [ADDR_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [ADDR_W-1:0]  phys_reg, phys_next;
    logic [SIZE_W-1:0]  slen_reg, slen_next;

    // Output registers
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] dst_x_reg, dst_x_next;
    logic [COORD_W-1:0] dst_y_reg, dst_y_next;
    logic [SIZE_W-1:0]  seg_width_reg, seg_width_next;
    logic [SIZE_W-1:0]  seg_height_reg, seg_height_next;
    logic [COORD_W-1:0] src_start_reg, src_start_next;
    logic               last_reg, last_next;

    // Shared datapath terms
    logic [ADDR_W-1:0]  fs_ext, span_ext, off_ext, fe;
    logic [ADDR_W-1:0]  s_addr, remaining, local_addr;
    logic [ADDR_W-1:0]  trial, p_addr, fe_gap, span_gap, fs_gap, seg_min, pos_end;
    logic               in_take, out_free, seg_last;

    // Configuration writes and reads
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_start_reg   <= '0;
            scroll_span_reg   <= '0;
            scroll_offset_reg <= '0;
            hw_scroll_on_reg  <= 1'b0;
            along_y_reg       <= 1'b1;
            axis_inverted_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_FIXED_START:   fixed_start_reg   <= pwdata[COORD_W-1:0];
                REG_SCROLL_SPAN:   scroll_span_reg   <= pwdata[SIZE_W-1:0];
                REG_SCROLL_OFFSET: scroll_offset_reg <= pwdata[COORD_W-1:0];
                REG_HW_SCROLL_ON:  hw_scroll_on_reg  <= pwdata[0];
                REG_ALONG_Y:       along_y_reg       <= pwdata[0];
                REG_AXIS_INVERTED: axis_inverted_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FIXED_START:   prdata = {{(PDATA_W-COORD_W){1'b0}}, fixed_start_reg};
            REG_SCROLL_SPAN:   prdata = {{(PDATA_W-SIZE_W){1'b0}}, scroll_span_reg};
            REG_SCROLL_OFFSET: prdata = {{(PDATA_W-COORD_W){1'b0}}, scroll_offset_reg};
            REG_HW_SCROLL_ON:  prdata = {{(PDATA_W-1){1'b0}}, hw_scroll_on_reg};
            REG_ALONG_Y:       prdata = {{(PDATA_W-1){1'b0}}, along_y_reg};
            REG_AXIS_INVERTED: prdata = {{(PDATA_W-1){1'b0}}, axis_inverted_reg};
            default:           prdata = '0;
        endcase
    end

    // Handshakes
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Line address terms of the current segment
    assign fs_ext     = {{(ADDR_W-COORD_W){1'b0}}, fixed_start_reg};
    assign span_ext   = {{(ADDR_W-SIZE_W){1'b0}}, scroll_span_reg};
    assign off_ext    = {{(ADDR_W-COORD_W){1'b0}}, scroll_offset_reg};
    assign fe         = fs_ext + span_ext;
    assign s_addr     = {{(ADDR_W-COORD_W){1'b0}}, start_reg}
                      + {{(ADDR_W-SIZE_W){1'b0}}, pos_reg};
    assign remaining  = {{(ADDR_W-SIZE_W){1'b0}}, len_reg - pos_reg};
    assign local_addr = s_addr - fs_ext;
    assign fs_gap     = fs_ext - s_addr;

    // Shared remainder step: shift in one dividend bit, subtract span when it fits
    assign trial = {rem_reg[ADDR_W-2:0], dvd_reg[ADDR_W-1]};

    // Fold the remainder back for a negative address, then clip the segment
    assign p_addr   = (neg_reg && (rem_reg != '0)) ? (span_ext - rem_reg) : rem_reg;
    assign fe_gap   = fe - s_addr;
    assign span_gap = span_ext - p_addr;

    always_comb
    begin
        seg_min = remaining;
        if (fe_gap < seg_min)
        begin
            seg_min = fe_gap;
        end
        if (span_gap < seg_min)
        begin
            seg_min = span_gap;
        end
    end

    // Segment end and last flag
    assign pos_end  = {{(ADDR_W-SIZE_W){1'b0}}, pos_reg}
                    + {{(ADDR_W-SIZE_W){1'b0}}, slen_reg};
    assign seg_last = pass_reg || (pos_end >= {{(ADDR_W-SIZE_W){1'b0}}, len_reg})
                    || (nseg_reg == LAST_SEG);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        nseg_next       = nseg_reg;
        pass_next       = pass_reg;
        neg_next        = neg_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        iter_next       = iter_reg;
        phys_next       = phys_reg;
        slen_next       = slen_reg;
        out_valid_next  = out_valid_reg && out_stall;
        dst_x_next      = dst_x_reg;
        dst_y_next      = dst_y_reg;
        seg_width_next  = seg_width_reg;
        seg_height_next = seg_height_reg;
        src_start_next  = src_start_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a rectangle; drop it at once when empty
                if (in_take && (rect_width != '0) && (rect_height != '0))
                begin
                    x0_next    = x_start;
                    y0_next    = y_start;
                    w_next     = rect_width;
                    h_next     = rect_height;
                    start_next = along_y_reg ? y_start : x_start;
                    len_next   = along_y_reg ? rect_height : rect_width;
                    pos_next   = '0;
                    nseg_next  = '0;
                    pass_next  = !hw_scroll_on_reg || (scroll_span_reg == '0);
                    state_next = (!hw_scroll_on_reg || (scroll_span_reg == '0))
                               ? ST_OUT : ST_SEG;
                end
            end

            ST_SEG:
            begin
                // Classify the next line: before, after or inside the window
                if (s_addr < fs_ext)
                begin
                    phys_next  = s_addr;
                    slen_next  = (fs_gap < remaining) ? fs_gap[SIZE_W-1:0]
                                                      : remaining[SIZE_W-1:0];
                    state_next = ST_OUT;
                end
                else if (s_addr >= fe)
                begin
                    phys_next  = s_addr;
                    slen_next  = remaining[SIZE_W-1:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    rem_next  = '0;
                    iter_next = ITER_W'(ADDR_W - 1);
                    if (!axis_inverted_reg)
                    begin
                        dvd_next = local_addr + off_ext;
                        neg_next = 1'b0;
                    end
                    else if (local_addr >= off_ext)
                    begin
                        dvd_next = local_addr - off_ext;
                        neg_next = 1'b0;
                    end
                    else
                    begin
                        dvd_next = off_ext - local_addr;
                        neg_next = 1'b1;
                    end
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // One remainder bit per cycle
                rem_next  = (trial >= span_ext) ? (trial - span_ext) : trial;
                dvd_next  = {dvd_reg[ADDR_W-2:0], 1'b0};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                // Map into the window and cut at the wrap point
                phys_next  = fs_ext + p_addr;
                slen_next  = seg_min[SIZE_W-1:0];
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                // Load the segment once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (pass_reg)
                    begin
                        dst_x_next      = x0_reg;
                        dst_y_next      = y0_reg;
                        seg_width_next  = w_reg;
                        seg_height_next = h_reg;
                        src_start_next  = '0;
                    end
                    else if (along_y_reg)
                    begin
                        dst_x_next      = x0_reg;
                        dst_y_next      = phys_reg[COORD_W-1:0];
                        seg_width_next  = w_reg;
                        seg_height_next = slen_reg;
                        src_start_next  = pos_reg[COORD_W-1:0];
                    end
                    else
                    begin
                        dst_x_next      = phys_reg[COORD_W-1:0];
                        dst_y_next      = y0_reg;
                        seg_width_next  = slen_reg;
                        seg_height_next = h_reg;
                        src_start_next  = pos_reg[COORD_W-1:0];
                    end
                    last_next  = seg_last;
                    pos_next   = pos_end[SIZE_W-1:0];
                    nseg_next  = nseg_reg + 1'b1;
                    state_next = seg_last ? ST_IDLE : ST_SEG;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        x0_reg         <= x0_next;
        y0_reg         <= y0_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        nseg_reg       <= nseg_next;
        pass_reg       <= pass_next;
        neg_reg        <= neg_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        iter_reg       <= iter_next;
        phys_reg       <= phys_next;
        slen_reg       <= slen_next;
        dst_x_reg      <= dst_x_next;
        dst_y_reg      <= dst_y_next;
        seg_width_reg  <= seg_width_next;
        seg_height_reg <= seg_height_next;
        src_start_reg  <= src_start_next;
        last_reg       <= last_next;
    end

    // Drive outputs
    assign out_valid  = out_valid_reg;
    assign dst_x      = dst_x_reg;
    assign dst_y      = dst_y_reg;
    assign seg_width  = seg_width_reg;
    assign seg_height = seg_height_reg;
    assign src_start  = src_start_reg;
    assign last       = last_reg;

endmodule
